FILE: hdl/bfgr_pkg.sv
package bfgr_pkg;

  // font store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_PITCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd4;

  localparam logic [31:0] RST_FB_BASE      = 32'd0;
  localparam logic [15:0] RST_FB_PITCH     = 16'd4096;
  localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT = 5'd16;
  localparam logic [8:0]  RST_GLYPH_COUNT  = 9'd256;

  localparam logic [3:0] PIX_PER_LINE = 4'd8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_COL,
    ST_ROW,
    ST_LINE0,
    ST_EMIT
  } state_t;

  // operands of the shared multiply-add unit: a * b + c
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [31:0] c;
  } mac_op_t;

endpackage

FILE: hdl/bfgr_ifs.sv
interface bfgr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] load_index;
  logic [7:0]  load_byte;
  logic [7:0]  cell_row;
  logic [7:0]  cell_col;
  logic [7:0]  char_code;
  logic [31:0] fg_color;
  logic [31:0] bg_color;

  modport source (
    output valid, cmd, load_index, load_byte, cell_row, cell_col, char_code,
           fg_color, bg_color,
    input  ready
  );
  modport sink (
    input  valid, cmd, load_index, load_byte, cell_row, cell_col, char_code,
           fg_color, bg_color,
    output ready
  );
endinterface

interface bfgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_address;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [31:0] pixel_4;
  logic [31:0] pixel_5;
  logic [31:0] pixel_6;
  logic [31:0] pixel_7;
  logic        last_line;

  modport source (
    output valid, line_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4,
           pixel_5, pixel_6, pixel_7, last_line,
    input  ready
  );
  modport sink (
    input  valid, line_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4,
           pixel_5, pixel_6, pixel_7, last_line,
    output ready
  );
endinterface

FILE: hdl/bitmap_font_glyph_renderer_top.sv
// Bitmap font character generator for a 32-bit-per-pixel linear framebuffer.
// A load beat (cmd 0) writes one glyph byte into the 4096-byte font store. A
// draw beat (cmd 1) produces one output beat per glyph line, carrying the
// line's byte address and eight pixel colors (pixels at and past glyph_width
// read 0), with last_line on the final line. In the setup states GLYPH, COL,
// ROW and LINE0 one shared multiply-add unit forms the glyph's store offset
// and the first line's address; then EMIT issues one line per cycle while
// the output is not stalled, set by the font store's single read port, and
// the read stage drains. The same unit steps the address by the pitch on
// every line. The input is not ready while a draw is in progress. Write
// configuration only while the block is idle. Store entries never written
// read as garbage.
module bitmap_font_glyph_renderer_top #(
  parameter int MAX_GLYPHS = 256,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bfgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  bfgr_in_if.sink                             in_ch,
  bfgr_out_if.source                          out_ch
);

  // configuration registers
  logic [31:0] fb_base;
  logic [15:0] fb_pitch;
  logic [3:0]  glyph_width;
  logic [4:0]  glyph_height;
  logic [8:0]  glyph_count;

  bfgr_pkg::state_t state, state_next;

  // per-draw context
  logic [7:0]  row;
  logic [7:0]  col;
  logic [7:0]  code;
  logic [31:0] fg;
  logic [31:0] bg;
  logic [3:0]  w_eff;
  logic [4:0]  h_eff;
  logic [31:0] acc;
  logic [12:0] rowh;
  logic [31:0] cur_addr;
  logic [bfgr_pkg::STORE_AW-1:0] rd_idx;
  logic [4:0]  lines_left;

  // read stage
  logic        s1_valid;
  logic [31:0] s1_addr;
  logic        s1_last;

  // output register
  logic        o_valid;
  logic [31:0] o_addr;
  logic [31:0] o_pix [8];
  logic        o_last;

  logic [3:0]  w_in;
  logic [4:0]  h_in;
  logic [8:0]  n_in;
  logic [7:0]  code_in;

  bfgr_pkg::mac_op_t mac_op;
  logic [31:0]       mac_res;

  logic        in_acc;
  logic        draw_acc;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic        out_load;
  logic        issue;

  // clamped config, sampled at draw accept
  always_comb begin
    w_in = glyph_width;
    if (glyph_width == 4'd0) begin
      w_in = 4'd1;
    end else if (glyph_width > bfgr_pkg::PIX_PER_LINE) begin
      w_in = bfgr_pkg::PIX_PER_LINE;
    end
    h_in = glyph_height;
    if (32'(glyph_height) > MAX_HEIGHT) begin
      h_in = 5'(MAX_HEIGHT);
    end
    n_in = glyph_count;
    if (32'(glyph_count) > MAX_GLYPHS) begin
      n_in = 9'(MAX_GLYPHS);
    end
    code_in = ({1'b0, in_ch.char_code} >= n_in) ? 8'd0 : in_ch.char_code;
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign draw_acc = in_acc && (in_ch.cmd == bfgr_pkg::CMD_DRAW);
  assign ram_we   = in_acc && (in_ch.cmd == bfgr_pkg::CMD_LOAD);

  assign out_load = s1_valid && (!o_valid || out_ch.ready);
  assign issue    = (state == bfgr_pkg::ST_EMIT) && (lines_left != 5'd0) &&
                    (!s1_valid || out_load);
  assign ram_re   = issue;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfgr_pkg::ST_IDLE:  if (draw_acc) state_next = bfgr_pkg::ST_GLYPH;
      bfgr_pkg::ST_GLYPH: state_next = bfgr_pkg::ST_COL;
      bfgr_pkg::ST_COL:   state_next = bfgr_pkg::ST_ROW;
      bfgr_pkg::ST_ROW:   state_next = bfgr_pkg::ST_LINE0;
      bfgr_pkg::ST_LINE0: state_next = bfgr_pkg::ST_EMIT;
      bfgr_pkg::ST_EMIT: begin
        if (lines_left == 5'd0 && (!s1_valid || out_load)) begin
          state_next = bfgr_pkg::ST_IDLE;
        end
      end
      default: state_next = bfgr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: input ready and the shared unit's operands
  always_comb begin
    in_ch.ready = 1'b0;
    mac_op      = '0;
    case (state)
      bfgr_pkg::ST_IDLE: in_ch.ready = 1'b1;
      bfgr_pkg::ST_GLYPH: begin
        mac_op.a = 16'(code);
        mac_op.b = 16'(h_eff);
      end
      bfgr_pkg::ST_COL: begin
        mac_op.a = 16'(col);
        mac_op.b = 16'({w_eff, 2'b00});
        mac_op.c = fb_base;
      end
      bfgr_pkg::ST_ROW: begin
        mac_op.a = 16'(row);
        mac_op.b = 16'(h_eff);
      end
      bfgr_pkg::ST_LINE0: begin
        mac_op.a = 16'(rowh);
        mac_op.b = fb_pitch;
        mac_op.c = acc;
      end
      bfgr_pkg::ST_EMIT: begin
        mac_op.a = fb_pitch;
        mac_op.b = 16'd1;
        mac_op.c = cur_addr;
      end
      default: mac_op = '0;
    endcase
  end

  bfgr_mac u_mac (
    .op  (mac_op),
    .res (mac_res)
  );

  bfgr_ram #(
    .WIDTH (8),
    .DEPTH (bfgr_pkg::STORE_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.load_index),
    .wdata (in_ch.load_byte),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_base      <= bfgr_pkg::RST_FB_BASE;
      fb_pitch     <= bfgr_pkg::RST_FB_PITCH;
      glyph_width  <= bfgr_pkg::RST_GLYPH_WIDTH;
      glyph_height <= bfgr_pkg::RST_GLYPH_HEIGHT;
      glyph_count  <= bfgr_pkg::RST_GLYPH_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        bfgr_pkg::REG_FB_BASE:      fb_base      <= cfg_data;
        bfgr_pkg::REG_FB_PITCH:     fb_pitch     <= cfg_data[15:0];
        bfgr_pkg::REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[3:0];
        bfgr_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[4:0];
        bfgr_pkg::REG_GLYPH_COUNT:  glyph_count  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfgr_pkg::ST_IDLE;
      s1_valid   <= 1'b0;
      o_valid    <= 1'b0;
      lines_left <= 5'd0;
    end else begin
      state <= state_next;
      if (state == bfgr_pkg::ST_LINE0) begin
        lines_left <= h_eff;
      end else if (issue) begin
        lines_left <= lines_left - 5'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      o_valid <= out_load || (o_valid && !out_ch.ready);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (draw_acc) begin
      row   <= in_ch.cell_row;
      col   <= in_ch.cell_col;
      code  <= code_in;
      fg    <= in_ch.fg_color;
      bg    <= in_ch.bg_color;
      w_eff <= w_in;
      h_eff <= h_in;
    end
    case (state)
      bfgr_pkg::ST_GLYPH: rd_idx   <= mac_res[bfgr_pkg::STORE_AW-1:0];
      bfgr_pkg::ST_COL:   acc      <= mac_res;
      bfgr_pkg::ST_ROW:   rowh     <= mac_res[12:0];
      bfgr_pkg::ST_LINE0: cur_addr <= mac_res;
      bfgr_pkg::ST_EMIT: begin
        if (issue) begin
          cur_addr <= mac_res;
          rd_idx   <= rd_idx + {{(bfgr_pkg::STORE_AW-1){1'b0}}, 1'b1};
          s1_addr  <= cur_addr;
          s1_last  <= (lines_left == 5'd1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      o_addr <= s1_addr;
      o_last <= s1_last;
      for (int x = 0; x < 8; x++) begin
        if (4'(x) < w_eff) begin
          o_pix[x] <= ram_rdata[7-x] ? fg : bg;
        end else begin
          o_pix[x] <= 32'd0;
        end
      end
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.line_address = o_addr;
  assign out_ch.pixel_0      = o_pix[0];
  assign out_ch.pixel_1      = o_pix[1];
  assign out_ch.pixel_2      = o_pix[2];
  assign out_ch.pixel_3      = o_pix[3];
  assign out_ch.pixel_4      = o_pix[4];
  assign out_ch.pixel_5      = o_pix[5];
  assign out_ch.pixel_6      = o_pix[6];
  assign out_ch.pixel_7      = o_pix[7];
  assign out_ch.last_line    = o_last;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == bfgr_pkg::ST_IDLE |-> !s1_valid && lines_left == 5'd0)
    else $error("read stage busy while idle");

  a_lines_bounded: assert property (@(posedge clk) disable iff (rst)
    state == bfgr_pkg::ST_EMIT |-> lines_left <= h_eff)
    else $error("line counter exceeds glyph height");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |-> lines_left == 5'd0)
    else $error("last line issued with lines remaining");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("font store written during a draw");

  a_load_fills_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> o_valid)
    else $error("output register lost a line");

endmodule

FILE: hdl/bfgr_ram.sv
module bfgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bfgr_mac.sv
module bfgr_mac (
  input  bfgr_pkg::mac_op_t op,
  output logic [31:0]       res
);

  logic [31:0] prod;

  assign prod = {16'b0, op.a} * {16'b0, op.b};
  assign res  = prod + op.c;

endmodule

FILE: tb/bitmap_font_glyph_renderer_top_test.sv
module bitmap_font_glyph_renderer_top_test;

  localparam int MAX_H        = 16;
  localparam int MAX_G        = 256;
  localparam int QUIET_LIMIT  = 1000;
  localparam int ITEMS_PER_PH = 45;

  typedef struct packed {
    logic        cmd;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [7:0]  char_code;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } glyph_cmd_t;

  typedef struct packed {
    logic [31:0]      addr;
    logic [7:0][31:0] pix;
    logic             last;
  } glyph_line_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [bfgr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfgr_pkg::CFG_DATA_W-1:0] cfg_data;

  bfgr_in_if  in_ch ();
  bfgr_out_if out_ch ();

  bitmap_font_glyph_renderer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block's registers and font store
  bit [31:0]   fb_base_q, fb_pitch_q, glyph_w_q, glyph_h_q, glyph_n_q;
  logic [7:0]  font_mirror [0:bfgr_pkg::STORE_DEPTH-1];
  bit          font_written [0:bfgr_pkg::STORE_DEPTH-1];
  glyph_line_t pending_lines [$];

  int  line_errors = 0;
  int  quiet_cycles = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  // work out the lines a draw produces, or update the font store on a load
  function automatic void render_glyph(glyph_cmd_t b);
    bit [31:0]   w, h, n, g, addr;
    logic [7:0]  bits;
    glyph_line_t ln;
    if (b.cmd == bfgr_pkg::CMD_LOAD) begin
      font_mirror[b.load_index]  = b.load_byte;
      font_written[b.load_index] = 1'b1;
      return;
    end
    w = glyph_w_q;
    if (w == 0) w = 1;
    if (w > 8) w = 8;
    h = glyph_h_q;
    if (h > MAX_H) h = MAX_H;
    n = glyph_n_q;
    if (n > MAX_G) n = MAX_G;
    g = 32'(b.char_code);
    if (g >= n) g = 0;
    addr = fb_base_q + 32'(b.cell_row) * h * fb_pitch_q + 32'(b.cell_col) * w * 32'd4;
    for (int y = 0; y < h; y++) begin
      bits = font_mirror[12'((g * h + 32'(y)) & (bfgr_pkg::STORE_DEPTH - 1))];
      ln.addr = addr;
      for (int x = 0; x < 8; x++)
        ln.pix[x] = (x < w) ? (bits[7 - x] ? b.fg_color : b.bg_color) : 32'd0;
      ln.last = (y + 1 == h);
      pending_lines.push_back(ln);
      addr = addr + fb_pitch_q;
    end
  endfunction

  function automatic glyph_cmd_t random_cmd();
    glyph_cmd_t b;
    b.cmd        = 1'($urandom_range(0, 1));
    b.load_index = 12'($urandom);
    b.load_byte  = 8'($urandom);
    b.cell_row   = 8'($urandom);
    b.cell_col   = 8'($urandom);
    b.char_code  = 8'($urandom);
    b.fg_color   = $urandom;
    b.bg_color   = $urandom;
    return b;
  endfunction

  // all tasks below start and end on a rising-edge step
  task automatic send_beat(glyph_cmd_t b);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= b.cmd;
    in_ch.load_index <= b.load_index;
    in_ch.load_byte  <= b.load_byte;
    in_ch.cell_row   <= b.cell_row;
    in_ch.cell_col   <= b.cell_col;
    in_ch.char_code  <= b.char_code;
    in_ch.fg_color   <= b.fg_color;
    in_ch.bg_color   <= b.bg_color;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    render_glyph(b);
    @(posedge clk);
  endtask

  task automatic pause(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic put_beat(glyph_cmd_t b);
    if (burst_left == 0) begin
      if (gaps_on) pause($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_beat(b);
  endtask

  task automatic settle(int n);
    in_ch.valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (n) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [bfgr_pkg::CFG_IDX_W-1:0] idx, bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(bit [31:0] base, pitch, width, height, count);
    settle(8);
    cfg_beat(bfgr_pkg::REG_FB_BASE, base);
    cfg_beat(bfgr_pkg::REG_FB_PITCH, pitch);
    cfg_beat(bfgr_pkg::REG_GLYPH_WIDTH, width);
    cfg_beat(bfgr_pkg::REG_GLYPH_HEIGHT, height);
    cfg_beat(bfgr_pkg::REG_GLYPH_COUNT, count);
    cfg_we <= 1'b0;
    fb_base_q  = base;
    fb_pitch_q = pitch & 32'hFFFF;
    glyph_w_q  = width & 32'hF;
    glyph_h_q  = height & 32'h1F;
    glyph_n_q  = count & 32'h1FF;
  endtask

  // reset geometry: a full 16-line glyph at the top of the store, drawn at
  // the far corner and at the origin with swapped colors
  task automatic test_full_height_glyph();
    logic [7:0] pat [16] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                             8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7, 8'h24, 8'hDB};
    glyph_cmd_t b;
    for (int y = 0; y < 16; y++) begin
      b = random_cmd();
      b.cmd        = bfgr_pkg::CMD_LOAD;
      b.load_index = 12'(4080 + y);
      b.load_byte  = pat[y];
      put_beat(b);
    end
    b = random_cmd();
    b.cmd       = bfgr_pkg::CMD_DRAW;
    b.char_code = 8'd255;
    b.cell_row  = 8'd255;
    b.cell_col  = 8'd255;
    b.fg_color  = 32'hFFFF_FFFF;
    b.bg_color  = 32'h0;
    put_beat(b);
    b.cell_row  = 8'd0;
    b.cell_col  = 8'd0;
    b.fg_color  = 32'h0;
    b.bg_color  = 32'hFFFF_FFFF;
    put_beat(b);
  endtask

  // single glyph, one pixel, one line; codes past the count fall back to
  // glyph 0 and addresses wrap past the top of memory
  task automatic test_code_out_of_range();
    glyph_cmd_t b;
    write_regs(32'hFFFF_FFFF, 32'd65535, 32'd1, 32'd1, 32'd1);
    b = random_cmd();
    b.cmd        = bfgr_pkg::CMD_LOAD;
    b.load_index = 12'd0;
    b.load_byte  = 8'h80;
    put_beat(b);
    b = random_cmd();
    b.cmd       = bfgr_pkg::CMD_DRAW;
    b.char_code = 8'd0;
    b.cell_row  = 8'd255;
    b.cell_col  = 8'd255;
    put_beat(b);
    b.char_code = 8'd255;
    put_beat(b);
    b = random_cmd();
    b.cmd        = bfgr_pkg::CMD_LOAD;
    b.load_index = 12'd0;
    b.load_byte  = 8'h7F;
    put_beat(b);
    b = random_cmd();
    b.cmd       = bfgr_pkg::CMD_DRAW;
    b.char_code = 8'd1;
    put_beat(b);
  endtask

  // mostly load-then-draw sequences; a few stray loads and draws dropped
  task automatic test_random_phase(bit [31:0] base, pitch, width, height, count,
                                   bit gaps);
    glyph_cmd_t b, ld;
    bit [31:0]  g;
    bit [11:0]  idx;
    int         sent;
    write_regs(base, pitch, width, height, count);
    gaps_on = gaps;
    sent = 0;
    while (sent < ITEMS_PER_PH) begin
      b = random_cmd();
      if ($urandom_range(0, 9) == 0) begin
        b.cmd = bfgr_pkg::CMD_LOAD;
        put_beat(b);
        sent++;
      end else begin
        b.cmd = bfgr_pkg::CMD_DRAW;
        if ($urandom_range(0, 1)) b.char_code = 8'($urandom_range(0, 7));
        g = (32'(b.char_code) >= glyph_n_q) ? 32'd0 : 32'(b.char_code);
        for (int y = 0; y < glyph_h_q; y++) begin
          idx = 12'(g * glyph_h_q + 32'(y));
          if (!font_written[idx] || $urandom_range(0, 7) == 0) begin
            ld = random_cmd();
            ld.cmd        = bfgr_pkg::CMD_LOAD;
            ld.load_index = idx;
            put_beat(ld);
            sent++;
          end
        end
        if ($urandom_range(0, 19) != 0) begin
          put_beat(b);
          sent++;
        end
      end
    end
  endtask

  // receiver: stalls follow a 32-bit pattern, redrawn when the tick counter's low six bits are zero
  bit [31:0] stall_pattern = 32'hFFFF_FFFF;
  bit [31:0] stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
    out_ch.ready <= stall_pattern[stall_tick[4:0]];
  end

  // sampled mid-cycle, so values are settled for the coming edge
  always @(negedge clk) begin : line_check
    glyph_line_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.addr = out_ch.line_address;
      got.pix  = {out_ch.pixel_7, out_ch.pixel_6, out_ch.pixel_5, out_ch.pixel_4,
                  out_ch.pixel_3, out_ch.pixel_2, out_ch.pixel_1, out_ch.pixel_0};
      got.last = out_ch.last_line;
      if (pending_lines.size() == 0) begin
        if (line_errors < 10)
          $display("unexpected line beat: addr=%h last=%b", got.addr, got.last);
        line_errors++;
      end else begin
        want = pending_lines.pop_front();
        if (got.addr !== want.addr || got.pix !== want.pix || got.last !== want.last) begin
          if (line_errors < 10) begin
            $display("line mismatch: exp addr=%h last=%b px=%h", want.addr, want.last,
                     want.pix);
            $display("               got addr=%h last=%b px=%h", got.addr, got.last,
                     got.pix);
          end
          line_errors++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= bfgr_pkg::CMD_LOAD;
    in_ch.load_index <= '0;
    in_ch.load_byte  <= '0;
    in_ch.cell_row   <= '0;
    in_ch.cell_col   <= '0;
    in_ch.char_code  <= '0;
    in_ch.fg_color   <= '0;
    in_ch.bg_color   <= '0;
    fb_base_q  = bfgr_pkg::RST_FB_BASE;
    fb_pitch_q = 32'(bfgr_pkg::RST_FB_PITCH);
    glyph_w_q  = 32'(bfgr_pkg::RST_GLYPH_WIDTH);
    glyph_h_q  = 32'(bfgr_pkg::RST_GLYPH_HEIGHT);
    glyph_n_q  = 32'(bfgr_pkg::RST_GLYPH_COUNT);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_full_height_glyph();
    test_code_out_of_range();
    test_random_phase(32'h0, 32'd4096, 32'd8, 32'd16, 32'd256, 1'b1);
    test_random_phase(32'hFFFF_FF00, 32'd65535, 32'd8, 32'd16, 32'd256, 1'b0);
    test_random_phase($urandom, 32'd0, 32'd1, 32'd1, 32'd1, 1'b1);
    test_random_phase($urandom, $urandom_range(0, 65535), $urandom_range(1, 8),
                      $urandom_range(1, 16), $urandom_range(1, 256), 1'b1);
    test_random_phase($urandom, 32'd2560, 32'd8, 32'd8, 32'd128, 1'b0);
    test_random_phase($urandom, $urandom_range(0, 65535), $urandom_range(1, 8),
                      $urandom_range(1, 16), $urandom_range(1, 256), 1'b1);
    test_random_phase($urandom, 32'd1, $urandom_range(1, 8), $urandom_range(1, 16),
                      32'd256, 1'b1);

    settle(20);
    if (line_errors == 0 && pending_lines.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
